>>> src/d8_flow_direction_macros.svh
// Assertion macros for the d8_flow_direction checker.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef D8_FLOW_DIRECTION_MACROS_SVH
`define D8_FLOW_DIRECTION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define D8FD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("d8_flow_direction: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define D8FD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("d8_flow_direction: next-cycle check failed");

`endif

>>> src/d8fd_pkg.sv
// Shared types and constants for the D8 flow direction block.
// No dependencies; used by the top level and its checker.
package d8fd_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_ELEV_BITS = 16;

    localparam int GRID_W_BITS   = 11;
    localparam int GRID_H_BITS   = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 1;

    localparam int DEF_GRID_W = 1024;
    localparam int DEF_GRID_H = 1024;
    localparam int MIN_GRID   = 3;

    localparam int DIAG_WEIGHT  = 46341;
    localparam int WEIGHT_SHIFT = 16;

    localparam int NUM_DIRS = 8;
    localparam int DIR_BITS = 3;

    typedef logic [DIR_BITS-1:0] dir_t;

    localparam dir_t DIR_NONE = dir_t'(0);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } cfg_reg_t;

endpackage

>>> src/d8_flow_direction.sv
// Streaming D8 steepest-descent flow direction over a raster elevation stream.
// Two line stores, a 3x3 window, weighted drops and a compare tree; uses d8fd_pkg.
//
// Channel  Signals                                 Handshake
// cfg      cfg_we, cfg_index, cfg_data             write on cfg_we, never stalls
// in       elevation                               in_valid / in_ready
// out      direction, cell_x, cell_y, frame_last   out_valid / out_ready
//
// One word per cycle sustained while out_ready is held high; an accepted word passes the
// line-store read register, weighted-drop register and result register to out_valid.
// Reset clears counters, window and valid bits and sets the grid to 1024 x 1024;
// the line stores are not cleared, each entry is written before a result uses it.
// A stalled result holds while both inner stages keep filling; in_ready drops
// only when all three stages are full. A config write restarts the frame.
module d8_flow_direction
    import d8fd_pkg::*;
#(
    parameter int  MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int  ELEV_BITS = DEF_ELEV_BITS,
    localparam int XW        = $clog2(MAX_WIDTH)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ELEV_BITS-1:0]     elevation,
    output logic                     out_valid,
    input  logic                     out_ready,
    output dir_t                     direction,
    output logic [XW-1:0]            cell_x,
    output logic [GRID_H_BITS-1:0]   cell_y,
    output logic                     frame_last
);

    localparam int EW = (XW + 1 > GRID_W_BITS) ? XW + 1 : GRID_W_BITS;
    localparam int DW = ELEV_BITS + WEIGHT_SHIFT + 1;
    localparam logic signed [DW-1:0] DIAG_COEF = DW'(DIAG_WEIGHT);

    logic [GRID_W_BITS-1:0] grid_w_reg;
    logic [GRID_H_BITS-1:0] grid_h_reg;
    logic [EW-1:0]          eff_w;
    logic [GRID_H_BITS-1:0] eff_h;

    logic [XW-1:0]          col_reg;
    logic [GRID_H_BITS-1:0] row_reg;
    logic                   x_end;
    logic                   y_end;

    logic                   out_free;
    logic                   s2_free;
    logic                   s1_free;
    logic                   s1_go;
    logic                   acc;

    logic                   s1_valid_reg;
    logic [ELEV_BITS-1:0]   s1_elev_reg;
    logic [XW-1:0]          s1_x_reg;
    logic [GRID_H_BITS-1:0] s1_y_reg;
    logic                   s1_prod_reg;
    logic                   s1_last_reg;
    logic [ELEV_BITS-1:0]   rd_prev_reg;
    logic [ELEV_BITS-1:0]   rd_prev2_reg;

    logic [ELEV_BITS-1:0]   prev_mem  [MAX_WIDTH];
    logic [ELEV_BITS-1:0]   prev2_mem [MAX_WIDTH];
    logic [ELEV_BITS-1:0]   win_reg   [6];

    logic [ELEV_BITS-1:0]   nb    [NUM_DIRS];
    logic signed [ELEV_BITS:0] diff [NUM_DIRS];
    logic signed [DW-1:0]   wdrop [NUM_DIRS];

    logic                   s2_valid_reg;
    logic signed [DW-1:0]   s2_drop_reg [NUM_DIRS];
    logic [XW-1:0]          s2_x_reg;
    logic [GRID_H_BITS-1:0] s2_y_reg;
    logic                   s2_last_reg;

    logic signed [DW-1:0]   v1 [4];
    dir_t                   c1 [4];
    logic signed [DW-1:0]   v2 [2];
    dir_t                   c2 [2];
    logic signed [DW-1:0]   v3;
    dir_t                   c3;
    dir_t                   best_dir;

    logic                   out_valid_reg;
    dir_t                   out_dir_reg;
    logic [XW-1:0]          out_x_reg;
    logic [GRID_H_BITS-1:0] out_y_reg;
    logic                   out_last_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_w_reg <= GRID_W_BITS'(DEF_GRID_W);
            grid_h_reg <= GRID_H_BITS'(DEF_GRID_H);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GRID_WIDTH:  grid_w_reg <= cfg_data[GRID_W_BITS-1:0];
                REG_GRID_HEIGHT: grid_h_reg <= cfg_data[GRID_H_BITS-1:0];
                default:         grid_w_reg <= grid_w_reg;
            endcase
        end
    end

    // clamp the grid size
    always_comb
    begin
        priority if (EW'(grid_w_reg) < EW'(MIN_GRID))
            eff_w = EW'(MIN_GRID);
        else if (EW'(grid_w_reg) > EW'(MAX_WIDTH))
            eff_w = EW'(MAX_WIDTH);
        else
            eff_w = EW'(grid_w_reg);
        eff_h = (grid_h_reg < GRID_H_BITS'(MIN_GRID)) ? GRID_H_BITS'(MIN_GRID) : grid_h_reg;
    end

    assign x_end = (EW'(col_reg) + EW'(1)) >= eff_w;
    assign y_end = ({1'b0, row_reg} + 17'd1) >= {1'b0, eff_h};

    // handshake
    assign out_free = !out_valid_reg || out_ready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s1_go    = s1_valid_reg && s2_free;
    assign in_ready = s1_free;
    assign acc      = in_valid && s1_free;

    // raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_we)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (acc)
        begin
            if (x_end)
            begin
                col_reg <= '0;
                row_reg <= y_end ? '0 : row_reg + GRID_H_BITS'(1);
            end
            else
            begin
                col_reg <= col_reg + XW'(1);
            end
        end
    end

    // stage 1: input word and line-store read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_free)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_elev_reg <= elevation;
            s1_x_reg    <= col_reg;
            s1_y_reg    <= row_reg;
            s1_prod_reg <= (col_reg >= XW'(2)) && (row_reg >= GRID_H_BITS'(2));
            s1_last_reg <= x_end && y_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
            prev_mem[s1_x_reg] <= s1_elev_reg;
        if (acc)
            rd_prev_reg <= prev_mem[col_reg];
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
            prev2_mem[s1_x_reg] <= rd_prev_reg;
        if (acc)
            rd_prev2_reg <= prev2_mem[col_reg];
    end

    // window: rows top, middle, bottom; columns x-2, x-1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (s1_go)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= rd_prev2_reg;
            win_reg[2] <= win_reg[3];
            win_reg[3] <= rd_prev_reg;
            win_reg[4] <= win_reg[5];
            win_reg[5] <= s1_elev_reg;
        end
    end

    // weighted drops from the centre toward each neighbour
    always_comb
    begin
        nb[0] = rd_prev_reg;
        nb[1] = rd_prev2_reg;
        nb[2] = win_reg[1];
        nb[3] = win_reg[0];
        nb[4] = win_reg[2];
        nb[5] = win_reg[4];
        nb[6] = win_reg[5];
        nb[7] = s1_elev_reg;
        for (int k = 0; k < NUM_DIRS; k++)
        begin
            diff[k] = $signed({1'b0, win_reg[3]}) - $signed({1'b0, nb[k]});
            if ((k & 1) == 1)
                wdrop[k] = DW'(diff[k]) * DIAG_COEF;
            else
                wdrop[k] = DW'(diff[k]) <<< WEIGHT_SHIFT;
        end
    end

    // stage 2: registered drops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_free)
            s2_valid_reg <= s1_valid_reg && s1_prod_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_free)
        begin
            for (int k = 0; k < NUM_DIRS; k++)
                s2_drop_reg[k] <= wdrop[k];
            s2_x_reg    <= s1_x_reg - XW'(1);
            s2_y_reg    <= s1_y_reg - GRID_H_BITS'(1);
            s2_last_reg <= s1_last_reg;
        end
    end

    // largest drop, lower code on a tie
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (s2_drop_reg[2*i+1] > s2_drop_reg[2*i])
            begin
                v1[i] = s2_drop_reg[2*i+1];
                c1[i] = dir_t'(2*i+1);
            end
            else
            begin
                v1[i] = s2_drop_reg[2*i];
                c1[i] = dir_t'(2*i);
            end
        end
        for (int i = 0; i < 2; i++)
        begin
            if (v1[2*i+1] > v1[2*i])
            begin
                v2[i] = v1[2*i+1];
                c2[i] = c1[2*i+1];
            end
            else
            begin
                v2[i] = v1[2*i];
                c2[i] = c1[2*i];
            end
        end
        if (v2[1] > v2[0])
        begin
            v3 = v2[1];
            c3 = c2[1];
        end
        else
        begin
            v3 = v2[0];
            c3 = c2[0];
        end
        best_dir = (!v3[DW-1] && (v3 != '0)) ? c3 : DIR_NONE;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_dir_reg  <= best_dir;
            out_x_reg    <= s2_x_reg;
            out_y_reg    <= s2_y_reg;
            out_last_reg <= s2_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign direction  = out_dir_reg;
    assign cell_x     = out_x_reg;
    assign cell_y     = out_y_reg;
    assign frame_last = out_last_reg;

endmodule

>>> src/d8fd_checker.sv
// Port-level checks for d8_flow_direction, bound to the top level.
// Depends on d8fd_pkg and d8_flow_direction_macros.svh.
`include "d8_flow_direction_macros.svh"

module d8fd_checker
    import d8fd_pkg::*;
#(
    parameter int  MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int XW        = $clog2(MAX_WIDTH)
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input dir_t                   direction,
    input logic [XW-1:0]          cell_x,
    input logic [GRID_H_BITS-1:0] cell_y,
    input logic                   frame_last
);

    `D8FD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `D8FD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(direction) && $stable(cell_x) && $stable(cell_y) && $stable(frame_last))
    `D8FD_ASSERT_IMPL(a_interior, out_valid, (cell_x != '0) && (cell_y != '0))
    `D8FD_ASSERT_IMPL(a_ready_empty, !out_valid, in_ready)

endmodule

bind d8_flow_direction d8fd_checker #(.MAX_WIDTH(MAX_WIDTH)) u_d8fd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .direction  (direction),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .frame_last (frame_last)
);

>>> bench/d8fd_board_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the D8 flow direction bench: a raster predictor with its own line
// stores, window and counters, and an in-order queue of expected codes. Needs d8fd_pkg.
package d8fd_board_pkg;
    import d8fd_pkg::*;

    localparam int LINE_CELLS = DEF_MAX_WIDTH;
    localparam int COL_BITS   = $clog2(DEF_MAX_WIDTH);
    localparam int REPORT_MAX = 10;

    typedef enum int {
        D8_EAST,
        D8_NORTH_EAST,
        D8_NORTH,
        D8_NORTH_WEST,
        D8_WEST,
        D8_SOUTH_WEST,
        D8_SOUTH,
        D8_SOUTH_EAST
    } d8_heading_t;

    typedef struct packed {
        dir_t                   code;
        logic [COL_BITS-1:0]    col;
        logic [GRID_H_BITS-1:0] row;
        logic                   frame_end;
    } flow_code_t;

    class flow_code_board;
        logic [15:0]            line_prev  [LINE_CELLS];
        logic [15:0]            line_prev2 [LINE_CELLS];
        logic [15:0]            win_cells  [3][2];
        int unsigned            col_cnt;
        int unsigned            row_cnt;
        logic [GRID_W_BITS-1:0] grid_w;
        logic [GRID_H_BITS-1:0] grid_h;
        flow_code_t             pending_codes [$];
        int unsigned            failures;

        function new();
            foreach (line_prev[i])
            begin
                line_prev[i]  = '0;
                line_prev2[i] = '0;
            end
            foreach (win_cells[r, c])
                win_cells[r][c] = '0;
            col_cnt  = 0;
            row_cnt  = 0;
            grid_w   = GRID_W_BITS'(DEF_GRID_W);
            grid_h   = GRID_H_BITS'(DEF_GRID_H);
            failures = 0;
        endfunction

        function int unsigned pending();
            return pending_codes.size();
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_GRID_WIDTH:  grid_w = data[GRID_W_BITS-1:0];
                REG_GRID_HEIGHT: grid_h = data[GRID_H_BITS-1:0];
                default: ;
            endcase
            col_cnt = 0;
            row_cnt = 0;
        endfunction

        function void take_sample(logic [15:0] elev);
            int unsigned w;
            int unsigned h;
            int unsigned idx;
            logic [15:0] col [3];
            longint      centre;
            longint      best;
            longint      nb;
            longint      drop;
            int          dx;
            int          dy;
            int          pick;
            int          k;
            flow_code_t  want;

            w = (grid_w < MIN_GRID) ? MIN_GRID : ((grid_w > LINE_CELLS) ? LINE_CELLS : grid_w);
            h = (grid_h < MIN_GRID) ? MIN_GRID : grid_h;
            idx = (col_cnt < LINE_CELLS) ? col_cnt : LINE_CELLS - 1;
            col[0] = line_prev2[idx];
            col[1] = line_prev[idx];
            col[2] = elev;

            if (col_cnt >= 2 && row_cnt >= 2)
            begin
                centre = longint'(win_cells[1][1]);
                best   = 0;
                pick   = D8_EAST;
                for (k = 0; k < NUM_DIRS; k++)
                begin
                    case (d8_heading_t'(k))
                        D8_EAST:       begin dx =  1; dy =  0; end
                        D8_NORTH_EAST: begin dx =  1; dy = -1; end
                        D8_NORTH:      begin dx =  0; dy = -1; end
                        D8_NORTH_WEST: begin dx = -1; dy = -1; end
                        D8_WEST:       begin dx = -1; dy =  0; end
                        D8_SOUTH_WEST: begin dx = -1; dy =  1; end
                        D8_SOUTH:      begin dx =  0; dy =  1; end
                        default:       begin dx =  1; dy =  1; end
                    endcase
                    if (dx == 1)
                        nb = longint'(col[dy + 1]);
                    else
                        nb = longint'(win_cells[dy + 1][dx + 1]);
                    drop = centre - nb;
                    if (dx != 0 && dy != 0)
                        drop = drop * DIAG_WEIGHT;
                    else
                        drop = drop * (longint'(1) << WEIGHT_SHIFT);
                    if (drop > best)
                    begin
                        best = drop;
                        pick = k;
                    end
                end
                want.code      = dir_t'(pick);
                want.col       = COL_BITS'(col_cnt - 1);
                want.row       = GRID_H_BITS'(row_cnt - 1);
                want.frame_end = (col_cnt == w - 1) && (row_cnt == h - 1);
                pending_codes = {pending_codes, want};
            end

            for (k = 0; k < 3; k++)
            begin
                win_cells[k][0] = win_cells[k][1];
                win_cells[k][1] = col[k];
            end
            line_prev2[idx] = col[1];
            line_prev[idx]  = col[2];

            if (col_cnt + 1 >= w)
            begin
                col_cnt = 0;
                row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
            end
            else
                col_cnt = col_cnt + 1;
        endfunction

        function void check_result(dir_t code, logic [COL_BITS-1:0] col,
                                   logic [GRID_H_BITS-1:0] row, logic frame_end);
            flow_code_t want;

            if (pending_codes.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("unexpected word: dir=%0d x=%0d y=%0d last=%0d",
                             code, col, row, frame_end);
                return;
            end
            want = pending_codes.pop_front();
            if (code !== want.code || col !== want.col || row !== want.row ||
                frame_end !== want.frame_end)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("mismatch: exp dir=%0d x=%0d y=%0d last=%0d,",
                             want.code, want.col, want.row, want.frame_end,
                             " got dir=%0d x=%0d y=%0d last=%0d",
                             code, col, row, frame_end);
            end
        endfunction

        function void close_out();
            if (pending_codes.size() != 0)
            begin
                failures += pending_codes.size();
                $display("%0d expected words never arrived", pending_codes.size());
            end
        endfunction
    endclass

endpackage

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// Top of the D8 flow direction bench: clock, reset, grid writes, elevation stream and
// result monitor with random idling and a long output hold. Needs d8fd_pkg, d8fd_board_pkg.
module tb_top;
    import d8fd_pkg::*;
    import d8fd_board_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 12;
    localparam int RANDOM_ITEMS    = 500;
    localparam int PHASE_CAP       = 150;
    localparam int CLAMP_ITEMS     = 40;

    typedef enum int {
        STYLE_FULL,
        STYLE_PLATEAU,
        STYLE_EXTREME
    } elev_style_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    logic [15:0]              elevation = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    dir_t                     direction;
    logic [COL_BITS-1:0]      cell_x;
    logic [GRID_H_BITS-1:0]   cell_y;
    logic                     frame_last;

    flow_code_board board = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_request  = 1'b0;
    int unsigned hold_left     = 0;
    int unsigned cycle_count   = 0;
    logic [15:0] opening_set [24];

    d8_flow_direction dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .elevation  (elevation),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .direction  (direction),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .frame_last (frame_last)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(direction, cell_x, cell_y, frame_last);
        if (hold_request)
        begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [15:0] pick_elevation(input logic [15:0] base);
        elev_style_t style;
        int unsigned roll;

        roll = $urandom_range(9);
        if (roll < 4)
            style = STYLE_FULL;
        else if (roll < 8)
            style = STYLE_PLATEAU;
        else
            style = STYLE_EXTREME;
        case (style)
            STYLE_FULL:    return 16'($urandom);
            STYLE_PLATEAU: return base + 16'($urandom_range(3));
            default:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    task automatic offer_elevation(input logic [15:0] elev);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        elevation <= elev;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.take_sample(elev);
    endtask

    task automatic run_phase(input int unsigned count, input logic [15:0] base);
        int unsigned i;

        for (i = 0; i < count; i++)
            offer_elevation(pick_elevation(base));
        in_valid <= 1'b0;
    endtask

    // drain: every expected word back, then let trailing border words clear the pipe
    task automatic settle();
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.write_reg(idx, data);
    endtask

    task automatic set_grid(input logic [CFG_DATA_BITS-1:0] w_data,
                            input logic [CFG_DATA_BITS-1:0] h_data);
        settle();
        if ($urandom_range(1))
        begin
            write_reg(REG_GRID_WIDTH, w_data);
            write_reg(REG_GRID_HEIGHT, h_data);
        end
        else
        begin
            write_reg(REG_GRID_HEIGHT, h_data);
            write_reg(REG_GRID_WIDTH, w_data);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int unsigned done;
        int unsigned n;
        int unsigned w;
        int unsigned h;
        int unsigned wide;
        int unsigned tall;
        int unsigned cap;
        int unsigned i;
        bit          big_done;

        opening_set = '{
            16'd900, 16'd500,  16'd900,
            16'd500, 16'd1000, 16'd500,
            16'd200, 16'd500,  16'd900,
            16'd0,   16'd0,    16'd0,
            16'd0,   16'd0,    16'd0,
            16'd0,   16'hFFFF, 16'd0,
            16'd0,   16'd0,    16'd0,
            16'hFFFF, 16'hFFFF, 16'hFFFF
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // two 3x4 frames: diagonal beating straight, ties, no lower neighbor, extremes
        set_grid(16'd3, 16'd4);
        for (i = 0; i < 24; i++)
            offer_elevation(opening_set[i]);
        in_valid <= 1'b0;

        done     = 0;
        big_done = 1'b0;
        while (done < RANDOM_ITEMS)
        begin
            if (done < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 22;
                recv_idle_pct = 87;
            end
            else if (done < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 87;
                recv_idle_pct = 22;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // widest clamp with height below minimum, then a long receiver hold on 8x8
            if (!big_done && done >= RANDOM_ITEMS / 2)
            begin
                set_grid(16'hFFFF, 16'd1);
                run_phase(CLAMP_ITEMS, 16'($urandom));
                set_grid(16'd8, 16'd8);
                hold_request = 1'b1;
                run_phase(PHASE_CAP, 16'($urandom));
                done += CLAMP_ITEMS + PHASE_CAP;
                big_done = 1'b1;
            end

            if ($urandom_range(9) < 7)
                w = $urandom_range(12);
            else
                w = $urandom_range(64, 13);
            i = $urandom_range(19);
            if (i < 15)
                h = $urandom_range(8);
            else if (i < 18)
                h = $urandom_range(16'hFFFF);
            else
                h = 16'hFFFF;
            wide = (w < MIN_GRID) ? MIN_GRID : w;
            tall = (h < MIN_GRID) ? MIN_GRID : h;
            cap  = 2 * wide * tall + wide;
            if (cap > PHASE_CAP)
                cap = PHASE_CAP;
            n = $urandom_range(cap, 1);

            set_grid({5'($urandom), 11'(w)}, 16'(h));
            if (done == 0)
                hold_request = 1'b1;
            run_phase(n, 16'($urandom));
            done += n;
        end

        settle();
        board.close_out();
        if (board.failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/d8fd_pkg.sv
src/d8_flow_direction.sv
src/d8fd_checker.sv
bench/d8fd_board_pkg.sv
bench/tb_top.sv
